### design/tmps_pkg.sv
// ----------------------------------------------------------------------------
// tmps_pkg
// Shared widths, constants and control types of the triangle path-sum block.
// ----------------------------------------------------------------------------
`default_nettype none

package tmps_pkg;

  localparam int ValW        = 16;
  localparam int SumW        = 25;
  localparam int RowCntW     = 10;
  localparam int MaxRowsDef  = 512;

  localparam logic signed [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};

  typedef struct packed {
    logic rd_en;
    logic advance;
    logic has_left;
    logic has_above;
    logic last_row;
    logic emit;
  } ctrl_t;

endpackage

`default_nettype wire

### design/tmps_row_mem.sv
// ----------------------------------------------------------------------------
// tmps_row_mem
// Row buffer of best path sums: one synchronous port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tmps_row_mem #(
  parameter int Depth = 512,
  parameter int Width = 25
) (
  input  wire logic                     clk_i,
  input  wire logic                     re_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule

`default_nettype wire

### design/tmps_ctrl.sv
// ----------------------------------------------------------------------------
// tmps_ctrl
// Sequencer: row and column position, read/update phases, edge flags.
// ----------------------------------------------------------------------------
`default_nettype none

module tmps_ctrl #(
  parameter int MaxRows = 512
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [tmps_pkg::RowCntW-1:0]  row_count_i,
  input  wire logic                          in_valid_i,
  input  wire logic                          out_busy_i,
  output logic                               in_ready_o,
  output logic [$clog2(MaxRows)-1:0]         addr_o,
  output tmps_pkg::ctrl_t                    ctrl_o
);

  import tmps_pkg::*;

  localparam int CW   = $clog2(MaxRows + 1);
  localparam int AW   = $clog2(MaxRows);
  localparam int CmpW = (CW > RowCntW) ? CW : RowCntW;

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StCalc = 2'b10
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;

  logic [CmpW-1:0] rc_ext;
  logic [CmpW-1:0] rows;
  logic            row_end;
  logic            last_row;
  logic            emit;
  logic            advance;
  logic            accept;

  always_comb begin
    rc_ext = CmpW'(row_count_i);
    if (rc_ext == '0) begin
      rows = CmpW'(1);
    end else if (rc_ext > CmpW'(MaxRows)) begin
      rows = CmpW'(MaxRows);
    end else begin
      rows = rc_ext;
    end
  end

  assign row_end  = (col_q >= row_q);
  assign last_row = (CmpW'(row_q) >= rows);
  assign emit     = row_end && last_row;
  assign addr_o   = AW'(col_q - CW'(1));

  always_comb begin
    in_ready_o = 1'b0;
    advance    = 1'b0;
    state_d    = state_q;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = StCalc;
        end
      end
      StCalc: begin
        if (!(emit && out_busy_i)) begin
          advance = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (advance) begin
      if (row_end) begin
        col_d = CW'(1);
        row_d = last_row ? CW'(1) : row_q + CW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      row_q   <= CW'(1);
      col_q   <= CW'(1);
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
    end
  end

  assign ctrl_o.rd_en     = accept;
  assign ctrl_o.advance   = advance;
  assign ctrl_o.has_left  = (col_q > CW'(1));
  assign ctrl_o.has_above = (col_q < row_q);
  assign ctrl_o.last_row  = last_row;
  assign ctrl_o.emit      = emit;

endmodule

`default_nettype wire

### design/triangle_max_path_sum.sv
// ----------------------------------------------------------------------------
// triangle_max_path_sum
// Maximum top-to-bottom path sum over a number triangle streamed row-major.
// ----------------------------------------------------------------------------
// Input channel value_i / value_valid_i / value_ready_o takes one triangle
// element per word, apex first, row r holding r elements. Output channel
// max_sum_o / max_sum_valid_o / max_sum_ready_i gives one word after the last
// element of the last row, then the block restarts at the apex.
// row_count_i must be written with row_count_we_i only while idle; the block
// does not enforce it. Zero counts as one row, more than MAX_ROWS as MAX_ROWS.
// Each element is handled as a read of the row buffer entry above it, then
// the add/compare and write-back of the same entry on the single memory port.
// The result is loaded into the output register at the last element's update.
// Reset returns the position to the apex and row_count to 1; no clearing pass
// runs, row buffer data is only used from entries written by the row before.
// A result waits in an output register; while it is not taken the block still
// accepts and processes elements, and stalls only when a next result is due.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_max_path_sum #(
  parameter int MAX_ROWS = tmps_pkg::MaxRowsDef
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                row_count_we_i,
  input  wire logic        [tmps_pkg::RowCntW-1:0] row_count_i,
  input  wire logic signed [tmps_pkg::ValW-1:0]    value_i,
  input  wire logic                                value_valid_i,
  output logic                                     value_ready_o,
  output logic signed      [tmps_pkg::SumW-1:0]    max_sum_o,
  output logic                                     max_sum_valid_o,
  input  wire logic                                max_sum_ready_i
);

  import tmps_pkg::*;

  localparam int AW = $clog2(MAX_ROWS);

  logic [RowCntW-1:0]      row_count_q;
  logic signed [ValW-1:0]  value_q;
  logic signed [SumW-1:0]  held_q, held_d;
  logic signed [SumW-1:0]  best_q, best_d;
  logic signed [SumW-1:0]  out_q, out_d;
  logic                    out_valid_q, out_valid_d;

  ctrl_t                   ctrl;
  logic [AW-1:0]           addr;
  logic [SumW-1:0]         rdata;
  logic signed [SumW-1:0]  above;
  logic signed [SumW-1:0]  pick;
  logic signed [SumW-1:0]  value_ext;
  logic signed [SumW-1:0]  sum;
  logic signed [SumW-1:0]  best_new;
  logic                    out_busy;

  assign out_busy = out_valid_q && !max_sum_ready_i;

  tmps_ctrl #(
    .MaxRows (MAX_ROWS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .row_count_i (row_count_q),
    .in_valid_i  (value_valid_i),
    .out_busy_i  (out_busy),
    .in_ready_o  (value_ready_o),
    .addr_o      (addr),
    .ctrl_o      (ctrl)
  );

  tmps_row_mem #(
    .Depth (MAX_ROWS),
    .Width (SumW)
  ) u_row_mem (
    .clk_i   (clk_i),
    .re_i    (ctrl.rd_en),
    .we_i    (ctrl.advance),
    .addr_i  (addr),
    .wdata_i (sum),
    .rdata_o (rdata)
  );

  always_comb begin
    above     = signed'(rdata);
    value_ext = {{(SumW-ValW){value_q[ValW-1]}}, value_q};
    if (ctrl.has_left && ctrl.has_above) begin
      pick = (held_q > above) ? held_q : above;
    end else if (ctrl.has_left) begin
      pick = held_q;
    end else if (ctrl.has_above) begin
      pick = above;
    end else begin
      pick = '0;
    end
    sum      = pick + value_ext;
    best_new = (ctrl.last_row && (sum > best_q)) ? sum : best_q;
  end

  always_comb begin
    held_d      = held_q;
    best_d      = best_q;
    out_d       = out_q;
    out_valid_d = max_sum_ready_i ? 1'b0 : out_valid_q;
    if (ctrl.advance) begin
      if (ctrl.emit) begin
        held_d      = '0;
        best_d      = SumMin;
        out_d       = best_new;
        out_valid_d = 1'b1;
      end else begin
        held_d = above;
        best_d = best_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= RowCntW'(1);
      held_q      <= '0;
      best_q      <= SumMin;
      out_valid_q <= 1'b0;
    end else begin
      if (row_count_we_i) begin
        row_count_q <= row_count_i;
      end
      held_q      <= held_d;
      best_q      <= best_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.rd_en) begin
      value_q <= value_i;
    end
    out_q <= out_d;
  end

  assign max_sum_o       = out_q;
  assign max_sum_valid_o = out_valid_q;

endmodule

`default_nettype wire

### design/tmps_checker.sv
// ----------------------------------------------------------------------------
// tmps_checker
// Port-level checks of the triangle path-sum block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tmps_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic signed [tmps_pkg::ValW-1:0]    value_i,
  input wire logic                                value_valid_i,
  input wire logic                                value_ready_o,
  input wire logic signed [tmps_pkg::SumW-1:0]    max_sum_o,
  input wire logic                                max_sum_valid_o,
  input wire logic                                max_sum_ready_i
);

  logic in_acc;
  assign in_acc = value_valid_i && value_ready_o;

  // hold a waiting input word
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    value_valid_i && !value_ready_o |=> value_valid_i && $stable(value_i))
    else $error("waiting input word changed");

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    max_sum_valid_o && !max_sum_ready_i |=> max_sum_valid_o && $stable(max_sum_o))
    else $error("stalled result word changed");

  // each element occupies the update phase after its acceptance
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !value_ready_o)
    else $error("input accepted during update phase");

  // advance out of the update phase unless the result register is blocked
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !value_ready_o && (!max_sum_valid_o || max_sum_ready_i) |=> value_ready_o)
    else $error("update phase held without a blocked result");

  // a fresh result is preceded by an accepted element and its update phase
  a_result_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(max_sum_valid_o) |-> $past(in_acc, 2))
    else $error("result word without a preceding element");

endmodule

bind triangle_max_path_sum tmps_checker u_tmps_checker (.*);

`default_nettype wire
